// ===== src/lpfd_pkg.sv =====
package lpfd_pkg;

    // Characters of the frame syntax.
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    // Limits of the payload value.
    localparam logic [15:0] MAG_LIMIT = 16'd32768;
    localparam logic [15:0] POS_MAX   = 16'd32767;

    // Reset value of the fault limit register.
    localparam logic [7:0] FAULT_LIMIT_RESET = 8'd50;

    // Status of the payload parser, seen by the frame controller.
    typedef struct packed {
        logic [1:0]  field_number;
        logic [15:0] magnitude;
        logic        negative;
        logic        digit_seen;
        logic        flag_nonzero;
        logic        parse_error;
    } parse_status_t;

    // Control from the frame controller to the payload parser.
    typedef struct packed {
        logic       clear;
        logic       enable;
        logic [7:0] data;
    } parse_ctrl_t;

    // One result item.
    typedef struct packed {
        logic               frame_ok;
        logic               frame_fault;
        logic [9:0]         payload_length;
        logic               joystick_valid;
        logic signed [15:0] joystick_value;
        logic               sprint_active;
        logic [15:0]        sequence_res;
        logic               link_dead;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

// ===== src/lpfd_in_stage.sv =====
module lpfd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       downstream_ready,
    output logic       step,
    output logic [7:0] step_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The held item moves on whenever the result register can take a result.
    assign step      = valid_reg && downstream_ready;
    assign s_ready   = !valid_reg || downstream_ready;
    assign step_byte = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (step) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on every accepted item.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule

// ===== src/lpfd_parser.sv =====
module lpfd_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lpfd_pkg::parse_ctrl_t  ctrl,
    output lpfd_pkg::parse_status_t status
);

    logic [1:0]  field_number_reg, field_number_next;
    logic [15:0] acc_reg, acc_next;
    logic        negative_reg, negative_next;
    logic        sign_seen_reg, sign_seen_next;
    logic        digit_seen_reg, digit_seen_next;
    logic        field_ended_reg, field_ended_next;
    logic        flag_reg, flag_next;
    logic        error_reg, error_next;
    logic [3:0]  digit;
    logic [19:0] acc_grown;

    assign digit     = 4'(ctrl.data - lpfd_pkg::CHAR_ZERO);
    assign acc_grown = {4'd0, acc_reg} * 20'd10 + {16'd0, digit};

    // One payload byte of the "value,flag" syntax.
    always_comb begin
        field_number_next = field_number_reg;
        acc_next          = acc_reg;
        negative_next     = negative_reg;
        sign_seen_next    = sign_seen_reg;
        digit_seen_next   = digit_seen_reg;
        field_ended_next  = field_ended_reg;
        flag_next         = flag_reg;
        error_next        = error_reg;
        if (ctrl.clear) begin
            field_number_next = 2'd0;
            acc_next          = 16'd0;
            negative_next     = 1'b0;
            sign_seen_next    = 1'b0;
            digit_seen_next   = 1'b0;
            field_ended_next  = 1'b0;
            flag_next         = 1'b0;
            error_next        = 1'b0;
        end else if (ctrl.enable && (field_number_reg < 2'd2)) begin
            if (ctrl.data == lpfd_pkg::CHAR_COMMA) begin
                if (!digit_seen_reg) begin
                    error_next = 1'b1;
                end
                field_number_next = field_number_reg + 2'd1;
                digit_seen_next   = 1'b0;
                field_ended_next  = 1'b0;
                sign_seen_next    = 1'b0;
            end else if (!field_ended_reg) begin
                if (lpfd_pkg::is_digit(ctrl.data)) begin
                    digit_seen_next = 1'b1;
                    if (field_number_reg == 2'd0) begin
                        if (acc_grown > {4'd0, lpfd_pkg::MAG_LIMIT}) begin
                            acc_next = lpfd_pkg::MAG_LIMIT;
                        end else begin
                            acc_next = acc_grown[15:0];
                        end
                    end else if (digit != 4'd0) begin
                        flag_next = 1'b1;
                    end
                end else if (digit_seen_reg) begin
                    field_ended_next = 1'b1;
                end else if (!sign_seen_reg && lpfd_pkg::is_space(ctrl.data)) begin
                    // Leading whitespace is skipped.
                end else if (!sign_seen_reg && ((ctrl.data == lpfd_pkg::CHAR_MINUS) ||
                                                (ctrl.data == lpfd_pkg::CHAR_PLUS))) begin
                    sign_seen_next = 1'b1;
                    if ((field_number_reg == 2'd0) && (ctrl.data == lpfd_pkg::CHAR_MINUS)) begin
                        negative_next = 1'b1;
                    end
                end else begin
                    error_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_number_reg <= 2'd0;
            acc_reg          <= 16'd0;
            negative_reg     <= 1'b0;
            sign_seen_reg    <= 1'b0;
            digit_seen_reg   <= 1'b0;
            field_ended_reg  <= 1'b0;
            flag_reg         <= 1'b0;
            error_reg        <= 1'b0;
        end else begin
            field_number_reg <= field_number_next;
            acc_reg          <= acc_next;
            negative_reg     <= negative_next;
            sign_seen_reg    <= sign_seen_next;
            digit_seen_reg   <= digit_seen_next;
            field_ended_reg  <= field_ended_next;
            flag_reg         <= flag_next;
            error_reg        <= error_next;
        end
    end

    assign status.field_number = field_number_reg;
    assign status.magnitude    = acc_reg;
    assign status.negative     = negative_reg;
    assign status.digit_seen   = digit_seen_reg;
    assign status.flag_nonzero = flag_reg;
    assign status.parse_error  = error_reg;

endmodule

// ===== src/lpfd_frame.sv =====
module lpfd_frame (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_write,
    input  logic [7:0]              cfg_fault_limit,
    input  logic                    step,
    input  logic [7:0]              step_byte,
    input  lpfd_pkg::parse_status_t status,
    output lpfd_pkg::parse_ctrl_t   ctrl,
    output logic                    res_valid,
    output lpfd_pkg::result_t       res
);

    typedef enum logic [2:0] {
        PH_DIGIT0,
        PH_DIGIT1,
        PH_DIGIT2,
        PH_COLON,
        PH_PAYLOAD,
        PH_NEWLINE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [9:0]  hlen_reg, hlen_next;
    logic [9:0]  left_reg, left_next;
    logic        hbad_reg, hbad_next;
    logic [7:0]  run_reg, run_next;
    logic        dead_reg, dead_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  limit_reg;
    logic [9:0]  hlen_base;
    logic [13:0] hlen_grown;
    logic [7:0]  run_inc;
    logic        joy_valid;
    logic [15:0] joy_value;

    assign hlen_base  = (phase_reg == PH_DIGIT0) ? 10'd0 : hlen_reg;
    assign hlen_grown = {4'd0, hlen_base} * 14'd10
                      + {10'd0, 4'(step_byte - lpfd_pkg::CHAR_ZERO)};
    assign run_inc    = (run_reg == 8'hFF) ? run_reg : run_reg + 8'd1;

    // Payload verdict, read when the closing newline arrives.
    assign joy_valid = !status.parse_error && (status.field_number != 2'd0) &&
                       ((status.field_number == 2'd2) || status.digit_seen);
    always_comb begin
        if (status.negative) begin
            joy_value = 16'(~status.magnitude + 16'd1);
        end else if (status.magnitude > lpfd_pkg::POS_MAX) begin
            joy_value = lpfd_pkg::POS_MAX;
        end else begin
            joy_value = status.magnitude;
        end
    end

    // Frame sequencing, fault counting and result formation for one item.
    always_comb begin
        phase_next  = phase_reg;
        hlen_next   = hlen_reg;
        left_next   = left_reg;
        hbad_next   = hbad_reg;
        run_next    = run_reg;
        dead_next   = dead_reg;
        count_next  = count_reg;
        ctrl.clear  = 1'b0;
        ctrl.enable = 1'b0;
        ctrl.data   = step_byte;
        res_valid   = 1'b0;
        res         = '0;
        if (step && !dead_reg) begin
            unique case (phase_reg)
                PH_DIGIT0, PH_DIGIT1, PH_DIGIT2: begin
                    hlen_next = hlen_base;
                    hbad_next = (phase_reg == PH_DIGIT0) ? 1'b0 : hbad_reg;
                    if (lpfd_pkg::is_digit(step_byte)) begin
                        hlen_next = hlen_grown[9:0];
                    end else begin
                        hbad_next = 1'b1;
                    end
                    phase_next = phase_t'(phase_reg + 3'd1);
                end
                PH_COLON: begin
                    if (hbad_reg || (step_byte != lpfd_pkg::CHAR_COLON)) begin
                        phase_next  = PH_DIGIT0;
                        run_next    = run_inc;
                        dead_next   = run_inc >= limit_reg;
                        res_valid   = 1'b1;
                        res.frame_fault = 1'b1;
                    end else begin
                        ctrl.clear = 1'b1;
                        left_next  = hlen_reg;
                        phase_next = (hlen_reg == 10'd0) ? PH_NEWLINE : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    ctrl.enable = 1'b1;
                    if (left_reg <= 10'd1) begin
                        left_next  = 10'd0;
                        phase_next = PH_NEWLINE;
                    end else begin
                        left_next = left_reg - 10'd1;
                    end
                end
                PH_NEWLINE: begin
                    phase_next = PH_DIGIT0;
                    res_valid  = 1'b1;
                    res.payload_length = hlen_reg;
                    if (step_byte != lpfd_pkg::CHAR_NEWLINE) begin
                        run_next  = run_inc;
                        dead_next = run_inc >= limit_reg;
                        res.frame_fault = 1'b1;
                    end else begin
                        run_next = 8'd0;
                        res.frame_ok = 1'b1;
                        if (joy_valid) begin
                            count_next         = count_reg + 16'd1;
                            res.joystick_valid = 1'b1;
                            res.joystick_value = joy_value;
                            res.sprint_active  = status.flag_nonzero;
                        end
                    end
                end
                default: begin
                    phase_next = PH_DIGIT0;
                end
            endcase
        end
        res.sequence_res = count_next;
        res.link_dead    = dead_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DIGIT0;
            hlen_reg  <= 10'd0;
            left_reg  <= 10'd0;
            hbad_reg  <= 1'b0;
            run_reg   <= 8'd0;
            dead_reg  <= 1'b0;
            count_reg <= 16'd0;
            limit_reg <= lpfd_pkg::FAULT_LIMIT_RESET;
        end else begin
            phase_reg <= phase_next;
            hlen_reg  <= hlen_next;
            left_reg  <= left_next;
            hbad_reg  <= hbad_next;
            run_reg   <= run_next;
            dead_reg  <= dead_next;
            count_reg <= count_next;
            if (cfg_write) begin
                limit_reg <= cfg_fault_limit;
            end
        end
    end

endmodule

// ===== src/lpfd_out_stage.sv =====
module lpfd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  lpfd_pkg::result_t res,
    output logic              can_take,
    output logic              m_valid,
    input  logic              m_ready,
    output lpfd_pkg::result_t m_res
);

    logic              valid_reg;
    logic              valid_next;
    lpfd_pkg::result_t res_reg;

    // The register takes a new result when empty or emptying this cycle.
    assign can_take = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        valid_next = valid_reg && !m_ready;
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// ===== src/length_prefixed_frame_deframer.sv =====
// Length-prefixed frame deframer.
// Input channel (s_valid, s_ready, s_rx_byte) takes one received byte per item.
// Frames are three ASCII length digits, a colon, the payload and a newline.
// The result channel (m_valid, m_ready, m_*) gives one item for each frame end
// or framing fault; bytes inside a frame give no result.
// The configuration channel (cfg_valid, cfg_ready, cfg_fault_limit) sets how
// many faults in a row declare the link dead; write it while the block is idle.
// Path: a byte is held in the input register, processed when the result register
// can take a result, and its result is registered there and driven on the m_ ports.
// Throughput: one byte per cycle while the result register can take a result, set
// by the single processing stage between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// keeps its byte; s_ready falls only when both are full.
// After link_dead is reported, further bytes are taken and dropped.
// Reset (aresetn low, synchronous) empties both registers, restarts the header
// search, clears the counters and loads a fault limit of 50.
module length_prefixed_frame_deframer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_ok,
    output logic               m_frame_fault,
    output logic [9:0]         m_payload_length,
    output logic               m_joystick_valid,
    output logic signed [15:0] m_joystick_value,
    output logic               m_sprint_active,
    output logic [15:0]        m_sequence_res,
    output logic               m_link_dead,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_fault_limit
);

    logic                    step;
    logic [7:0]              step_byte;
    logic                    can_take;
    logic                    res_valid;
    lpfd_pkg::result_t       res;
    lpfd_pkg::result_t       m_res;
    lpfd_pkg::parse_ctrl_t   ctrl;
    lpfd_pkg::parse_status_t status;

    // The configuration register is always ready.
    assign cfg_ready = 1'b1;

    lpfd_in_stage u_in_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .downstream_ready (can_take),
        .step             (step),
        .step_byte        (step_byte)
    );

    lpfd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .status  (status)
    );

    lpfd_frame u_frame (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_fault_limit (cfg_fault_limit),
        .step            (step),
        .step_byte       (step_byte),
        .status          (status),
        .ctrl            (ctrl),
        .res_valid       (res_valid),
        .res             (res)
    );

    lpfd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .can_take (can_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    // Result fields onto their own ports.
    assign m_frame_ok       = m_res.frame_ok;
    assign m_frame_fault    = m_res.frame_fault;
    assign m_payload_length = m_res.payload_length;
    assign m_joystick_valid = m_res.joystick_valid;
    assign m_joystick_value = m_res.joystick_value;
    assign m_sprint_active  = m_res.sprint_active;
    assign m_sequence_res   = m_res.sequence_res;
    assign m_link_dead      = m_res.link_dead;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Phases of the frame parser.
    localparam logic [2:0] PH_LEN0    = 3'd0;
    localparam logic [2:0] PH_LEN1    = 3'd1;
    localparam logic [2:0] PH_LEN2    = 3'd2;
    localparam logic [2:0] PH_COLON   = 3'd3;
    localparam logic [2:0] PH_BODY    = 3'd4;
    localparam logic [2:0] PH_NEWLINE = 3'd5;

    // Control characters around the whitespace range.
    localparam logic [7:0] CHAR_BS = 8'h08;
    localparam logic [7:0] CHAR_VT = 8'h0B;
    localparam logic [7:0] CHAR_FF = 8'h0C;
    localparam logic [7:0] CHAR_SO = 8'h0E;

    localparam int CYCLE_LIMIT = 300000;
    localparam int FAULT_MARGIN = 16;

    typedef struct packed {
        logic [2:0]  phase;
        logic [9:0]  hdr_len;
        logic [9:0]  left;
        logic        hdr_bad;
        logic [1:0]  field_no;
        logic [16:0] acc;
        logic        neg;
        logic        sign_seen;
        logic        digit_seen;
        logic        field_ended;
        logic        flag_nz;
        logic        perr;
        logic [7:0]  fault_run;
        logic        dead;
        logic [15:0] seq;
        logic [7:0]  limit;
    } deframer_state_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'd0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_frame_ok;
    logic               m_frame_fault;
    logic [9:0]         m_payload_length;
    logic               m_joystick_valid;
    logic signed [15:0] m_joystick_value;
    logic               m_sprint_active;
    logic [15:0]        m_sequence_res;
    logic               m_link_dead;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_fault_limit = 8'd0;

    logic [7:0]          rx_bytes_pending[$];
    logic [7:0]          body_bytes[$];
    lpfd_pkg::result_t   expected_reports[$];
    deframer_state_t     link_state;
    deframer_state_t     planned_state;
    lpfd_pkg::result_t   seen_report;
    lpfd_pkg::result_t   wanted_report;
    lpfd_pkg::result_t   accept_report;
    bit                  accept_has_report;
    int                  pushed_total = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;

    length_prefixed_frame_deframer uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_ok       (m_frame_ok),
        .m_frame_fault    (m_frame_fault),
        .m_payload_length (m_payload_length),
        .m_joystick_valid (m_joystick_valid),
        .m_joystick_value (m_joystick_value),
        .m_sprint_active  (m_sprint_active),
        .m_sequence_res   (m_sequence_res),
        .m_link_dead      (m_link_dead),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_fault_limit  (cfg_fault_limit)
    );

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Advances the deframer by one received byte and tells whether a result is due.
    task automatic deframe_byte(inout deframer_state_t st, input logic [7:0] c,
                                output bit has_report, output lpfd_pkg::result_t rep);
        bit          is_dig;
        bit          is_ws;
        bit          fault;
        int unsigned mag;
        logic [16:0] neg_val;
        is_dig = (c >= lpfd_pkg::CHAR_ZERO) && (c <= lpfd_pkg::CHAR_NINE);
        is_ws = (c == lpfd_pkg::CHAR_SPACE) ||
                ((c >= lpfd_pkg::CHAR_TAB) && (c <= lpfd_pkg::CHAR_CR));
        has_report = 1'b0;
        rep = '0;
        fault = 1'b0;
        if (!st.dead) begin
            case (st.phase)
                PH_LEN0, PH_LEN1, PH_LEN2: begin
                    if (st.phase == PH_LEN0) begin
                        st.hdr_len = '0;
                        st.hdr_bad = 1'b0;
                    end
                    if (is_dig) begin
                        st.hdr_len = 10'(st.hdr_len * 10 + (c - lpfd_pkg::CHAR_ZERO));
                    end else begin
                        st.hdr_bad = 1'b1;
                    end
                    st.phase = st.phase + 3'd1;
                end
                PH_COLON: begin
                    if (st.hdr_bad || (c != lpfd_pkg::CHAR_COLON)) begin
                        st.phase = PH_LEN0;
                        fault = 1'b1;
                    end else begin
                        st.field_no = '0;
                        st.acc = '0;
                        st.neg = 1'b0;
                        st.sign_seen = 1'b0;
                        st.digit_seen = 1'b0;
                        st.field_ended = 1'b0;
                        st.flag_nz = 1'b0;
                        st.perr = 1'b0;
                        st.left = st.hdr_len;
                        st.phase = (st.hdr_len == 0) ? PH_NEWLINE : PH_BODY;
                    end
                end
                PH_BODY: begin
                    // Payload fields are parsed only up to the second one.
                    if (st.field_no < 2) begin
                        if (c == lpfd_pkg::CHAR_COMMA) begin
                            if (!st.digit_seen) begin
                                st.perr = 1'b1;
                            end
                            st.field_no = st.field_no + 2'd1;
                            st.digit_seen = 1'b0;
                            st.field_ended = 1'b0;
                            st.sign_seen = 1'b0;
                        end else if (!st.field_ended) begin
                            if (is_dig) begin
                                st.digit_seen = 1'b1;
                                if (st.field_no == 0) begin
                                    mag = st.acc * 10 + (c - lpfd_pkg::CHAR_ZERO);
                                    st.acc = 17'((mag > lpfd_pkg::MAG_LIMIT) ?
                                                 lpfd_pkg::MAG_LIMIT : mag);
                                end else if (c != lpfd_pkg::CHAR_ZERO) begin
                                    st.flag_nz = 1'b1;
                                end
                            end else if (st.digit_seen) begin
                                st.field_ended = 1'b1;
                            end else if (!st.sign_seen && is_ws) begin
                                // Leading whitespace is skipped.
                            end else if (!st.sign_seen &&
                                         ((c == lpfd_pkg::CHAR_MINUS) ||
                                          (c == lpfd_pkg::CHAR_PLUS))) begin
                                st.sign_seen = 1'b1;
                                if ((st.field_no == 0) && (c == lpfd_pkg::CHAR_MINUS)) begin
                                    st.neg = 1'b1;
                                end
                            end else begin
                                st.perr = 1'b1;
                            end
                        end
                    end
                    if (st.left != 0) begin
                        st.left = st.left - 10'd1;
                    end
                    if (st.left == 0) begin
                        st.phase = PH_NEWLINE;
                    end
                end
                default: begin
                    st.phase = PH_LEN0;
                    if (c != lpfd_pkg::CHAR_NEWLINE) begin
                        fault = 1'b1;
                        rep.payload_length = st.hdr_len;
                    end else begin
                        st.fault_run = '0;
                        rep.frame_ok = 1'b1;
                        rep.payload_length = st.hdr_len;
                        if (!st.perr && (st.field_no >= 1) &&
                            ((st.field_no >= 2) || st.digit_seen)) begin
                            neg_val = 17'h10000 - st.acc;
                            rep.joystick_valid = 1'b1;
                            if (st.neg) begin
                                rep.joystick_value = neg_val[15:0];
                            end else begin
                                rep.joystick_value = (st.acc > lpfd_pkg::POS_MAX) ?
                                                     lpfd_pkg::POS_MAX : st.acc[15:0];
                            end
                            rep.sprint_active = st.flag_nz;
                            st.seq = st.seq + 16'd1;
                        end
                        rep.sequence_res = st.seq;
                        rep.link_dead = st.dead;
                        has_report = 1'b1;
                    end
                end
            endcase
            // A fault extends the run and may kill the link.
            if (fault) begin
                if (st.fault_run != 8'd255) begin
                    st.fault_run = st.fault_run + 8'd1;
                end
                if (st.fault_run >= st.limit) begin
                    st.dead = 1'b1;
                end
                rep.frame_fault = 1'b1;
                rep.sequence_res = st.seq;
                rep.link_dead = st.dead;
                has_report = 1'b1;
            end
        end
    endtask

    function automatic string report_text(input lpfd_pkg::result_t r);
        return $sformatf({"ok=%0d fault=%0d len=%0d joy=%0d val=%0d sprint=%0d ",
                          "seq=%0d dead=%0d"},
                         r.frame_ok, r.frame_fault, r.payload_length, r.joystick_valid,
                         $signed(r.joystick_value), r.sprint_active, r.sequence_res,
                         r.link_dead);
    endfunction

    // Queues one byte for the sender and tracks where the stream will leave the parser.
    task automatic push_byte(input logic [7:0] c);
        bit                has_report;
        lpfd_pkg::result_t rep;
        rx_bytes_pending.insert(rx_bytes_pending.size(), c);
        pushed_total++;
        deframe_byte(planned_state, c, has_report, rep);
    endtask

    task automatic add_byte(input logic [7:0] c);
        body_bytes.insert(body_bytes.size(), c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            body_bytes.insert(body_bytes.size(), s[i]);
        end
    endtask

    // Sends the collected bytes as they are, with no framing.
    task automatic push_raw();
        for (int i = 0; i < body_bytes.size(); i++) begin
            push_byte(body_bytes[i]);
        end
        body_bytes.delete();
    endtask

    // Sends a header with the given length, the collected payload and a closing byte.
    task automatic push_frame(input int declared, input logic [7:0] closing);
        push_byte(8'(lpfd_pkg::CHAR_ZERO + declared / 100));
        push_byte(8'(lpfd_pkg::CHAR_ZERO + (declared / 10) % 10));
        push_byte(8'(lpfd_pkg::CHAR_ZERO + declared % 10));
        push_byte(lpfd_pkg::CHAR_COLON);
        push_raw();
        push_byte(closing);
    endtask

    // Feeds filler until the parser is back at the start of a header or the link is dead.
    task automatic resync();
        while ((planned_state.phase != PH_LEN0) && !planned_state.dead) begin
            case (planned_state.phase)
                PH_COLON:   push_byte(lpfd_pkg::CHAR_COLON);
                PH_BODY:    push_byte(lpfd_pkg::CHAR_SPACE);
                PH_NEWLINE: push_byte(lpfd_pkg::CHAR_NEWLINE);
                default:    push_byte(lpfd_pkg::CHAR_ZERO);
            endcase
        end
    endtask

    // One payload field: whitespace, sign, digits and trailing junk, each optional.
    task automatic add_field();
        int n;
        n = $urandom_range(2);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(5))
                0: add_byte(lpfd_pkg::CHAR_SPACE);
                1: add_byte(lpfd_pkg::CHAR_TAB);
                2: add_byte(lpfd_pkg::CHAR_NEWLINE);
                3: add_byte(CHAR_VT);
                4: add_byte(CHAR_FF);
                default: add_byte(lpfd_pkg::CHAR_CR);
            endcase
        end
        case ($urandom_range(3))
            0: add_byte(lpfd_pkg::CHAR_MINUS);
            1: add_byte(lpfd_pkg::CHAR_PLUS);
            default: ;
        endcase
        if ($urandom_range(19) == 0) begin
            n = 0;
        end else if ($urandom_range(4) == 0) begin
            n = $urandom_range(4, 7);
        end else begin
            n = $urandom_range(1, 3);
        end
        for (int i = 0; i < n; i++) begin
            add_byte(($urandom_range(2) == 0) ? lpfd_pkg::CHAR_ZERO :
                     8'(lpfd_pkg::CHAR_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(5) == 0) begin
            add_byte(8'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    // A "value,flag" payload, sometimes without the comma, with an extra field or a stray character.
    task automatic add_joystick_body();
        add_field();
        if ($urandom_range(9) != 0) begin
            add_byte(lpfd_pkg::CHAR_COMMA);
        end
        add_field();
        if ($urandom_range(4) == 0) begin
            add_text(",9x");
        end
        if ($urandom_range(11) == 0) begin
            body_bytes.insert($urandom_range(body_bytes.size()),
                              8'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    // Random traffic: mostly well-formed frames, the rest broken frames and noise.
    task automatic gen_traffic(input int count);
        int         start;
        int         k;
        int         n;
        int         delta;
        logic [7:0] b;
        start = pushed_total;
        while (pushed_total - start < count) begin
            k = $urandom_range(99);
            if ((k >= 90) && (planned_state.fault_run + FAULT_MARGIN < planned_state.limit)) begin
                n = $urandom_range(1, 36);
                for (int i = 0; i < n; i++) begin
                    push_byte(8'($urandom_range(255)));
                end
            end else begin
                resync();
                if (planned_state.fault_run + FAULT_MARGIN >= planned_state.limit) begin
                    // A good frame ends the fault run before it gets near the limit.
                    add_text("1,1");
                    push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
                end else if (k < 65) begin
                    add_joystick_body();
                    push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
                end else if (k < 73) begin
                    n = ($urandom_range(39) == 0) ? $urandom_range(100, 250) : $urandom_range(20);
                    for (int i = 0; i < n; i++) begin
                        add_byte(8'($urandom_range(255)));
                    end
                    push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
                end else if (k < 82) begin
                    add_joystick_body();
                    if ($urandom_range(1) == 0) begin
                        push_frame(body_bytes.size(), 8'($urandom_range(255)));
                    end else begin
                        delta = $urandom_range(1, 3);
                        n = body_bytes.size();
                        if (($urandom_range(1) == 0) && (n >= delta)) begin
                            push_frame(n - delta, lpfd_pkg::CHAR_NEWLINE);
                        end else begin
                            push_frame(n + delta, lpfd_pkg::CHAR_NEWLINE);
                        end
                    end
                end else begin
                    n = $urandom_range(3);
                    for (int i = 0; i < 4; i++) begin
                        b = (i == 3) ? lpfd_pkg::CHAR_COLON :
                            8'(lpfd_pkg::CHAR_ZERO + $urandom_range(9));
                        if (i == n) begin
                            b = 8'($urandom_range(255));
                            if ((b == lpfd_pkg::CHAR_COLON) ||
                                ((b >= lpfd_pkg::CHAR_ZERO) && (b <= lpfd_pkg::CHAR_NINE))) begin
                                b = b ^ 8'h80;
                            end
                        end
                        add_byte(b);
                    end
                    push_raw();
                end
            end
        end
    endtask

    // Waits until every byte is taken and every result is in, then lets the pipeline empty.
    task automatic wait_idle();
        do @(negedge aclk);
        while ((rx_bytes_pending.size() != 0) || s_valid || (expected_reports.size() != 0));
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_fault_limit <= value;
        do @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        link_state.limit = value;
        planned_state.limit = value;
        @(negedge aclk);
    endtask

    // Sender: offers the next pending byte and predicts each byte that is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                deframe_byte(link_state, s_rx_byte, accept_has_report, accept_report);
                if (accept_has_report) begin
                    expected_reports.insert(expected_reports.size(), accept_report);
                end
            end
            if (!s_valid || s_ready) begin
                if ((rx_bytes_pending.size() != 0) && ($urandom_range(99) >= send_idle_pct)) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= rx_bytes_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: each accepted item against the oldest expected one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_report = {m_frame_ok, m_frame_fault, m_payload_length, m_joystick_valid,
                           m_joystick_value, m_sprint_active, m_sequence_res, m_link_dead};
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result at %0t: %s", $realtime, report_text(seen_report));
                end
            end else begin
                wanted_report = expected_reports.pop_front();
                if (seen_report !== wanted_report) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at %0t: expected %s", $realtime,
                                 report_text(wanted_report));
                        $display("                 actual   %s", report_text(seen_report));
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("length_prefixed_frame_deframer test failed");
            $finish;
        end
    end

    initial begin
        link_state = '0;
        link_state.limit = lpfd_pkg::FAULT_LIMIT_RESET;
        planned_state = link_state;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames: saturation, signs, whitespace, malformed payloads.
        add_text("12,1");        push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("-32768,0");    push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("32768,5");     push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("-99999,007");  push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("+0,000");      push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_byte(lpfd_pkg::CHAR_TAB);
        add_byte(lpfd_pkg::CHAR_CR);
        add_byte(CHAR_VT);
        add_byte(CHAR_FF);
        add_byte(lpfd_pkg::CHAR_NEWLINE);
        add_byte(lpfd_pkg::CHAR_SPACE);
        add_text("-7 x,  +3junk,9");
        push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("5");           push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("5,");          push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text(",1");          push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("++5,1");       push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("- 5,1");       push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_byte(CHAR_BS);
        add_text("5,1");
        push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("5,");
        add_byte(CHAR_SO);
        add_text("1");
        push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        push_frame(0, lpfd_pkg::CHAR_NEWLINE);

        // Bad headers at the first, third and colon positions, then a missing newline.
        add_text("/00:");        push_raw();
        add_text(":12:");        push_raw();
        add_text("00A:");        push_raw();
        add_text("000;");        push_raw();
        add_text("9999");        push_raw();
        add_text("1,1");         push_frame(3, "X");
        add_text("2,0");         push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        wait_idle();

        // Random traffic with the largest limit and the longest frame, no idling.
        write_limit(8'd255);
        add_text("-123,4");
        while (body_bytes.size() < 999) begin
            add_byte(8'($urandom_range(255)));
        end
        push_frame(999, lpfd_pkg::CHAR_NEWLINE);
        gen_traffic(100);
        wait_idle();

        // Sender idling.
        write_limit(8'($urandom_range(40, 254)));
        send_idle_pct = 64;
        gen_traffic(100);
        wait_idle();

        // Receiver stalling with a tight limit.
        write_limit(8'd40);
        send_idle_pct = 0;
        recv_stall_pct = 64;
        gen_traffic(100);
        wait_idle();

        // Both sides idling, then a good frame on a header boundary to clear the fault run.
        write_limit(8'($urandom_range(40, 254)));
        send_idle_pct = 22;
        recv_stall_pct = 22;
        gen_traffic(100);
        resync();
        add_text("1,1");         push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        wait_idle();

        // Limit of two: single faults separated by good frames leave the link up.
        write_limit(8'd2);
        add_text("0:0:");        push_raw();
        add_text("2,1");         push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("4,0");         push_frame(3, lpfd_pkg::CHAR_SPACE);
        add_text("6,1");         push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        wait_idle();

        // Limit of one with good frames only.
        write_limit(8'd1);
        add_text("-1,1");        push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("1,0");         push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        wait_idle();

        // Limit of zero: the first fault kills the link and later bytes are dropped.
        write_limit(8'd0);
        add_text("3,3");         push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        add_text("abcd");        push_raw();
        add_text("5,5");         push_frame(body_bytes.size(), lpfd_pkg::CHAR_NEWLINE);
        for (int i = 0; i < 40; i++) begin
            push_byte(8'($urandom_range(255)));
        end
        wait_idle();

        if (expected_reports.size() != 0) begin
            $display("%0d expected results never arrived", expected_reports.size());
        end
        if ((mismatch_count == 0) && (expected_reports.size() == 0)) begin
            $display("length_prefixed_frame_deframer test passed");
        end else begin
            $display("length_prefixed_frame_deframer test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lpfd_pkg.sv
src/lpfd_in_stage.sv
src/lpfd_parser.sv
src/lpfd_frame.sv
src/lpfd_out_stage.sv
src/length_prefixed_frame_deframer.sv
tb/sv/testbench.sv
